// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the detiler RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("detiler assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

// ===== rtl/core/nv12dt_pkg.sv =====
// Types and constants shared by the tiled NV12 detiler files.
`timescale 1ns / 1ps
`default_nettype none

package nv12dt_pkg;

    // Configuration register fields and index codes.
    localparam int CFG_W = 13;
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 1'b0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1280;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd720;

    // Tile geometry.
    localparam int TILE_W        = 16;
    localparam int TILE_W_LOG2   = 4;
    localparam int LUMA_TILE_H   = 16;
    localparam int CHROMA_TILE_H = 8;
    localparam int CHROMA_TILE_H_LOG2 = 3;
    localparam int WORDS_PER_ROW = 4;

    // Pixel position width and output address width.
    localparam int POS_W  = 14;
    localparam int ADDR_W = 24;

    typedef struct packed {
        logic              is_chroma;
        logic [ADDR_W-1:0] linear_address;
        logic [3:0][7:0]   lanes;
        logic [3:0]        lane_mask;
        logic              frame_last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/nv12dt_obuf.sv =====
// Two-entry output buffer (output register plus skid entry) for detiler writes.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nv12dt_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  nv12dt_pkg::t_result i_data,
    output logic                o_full,
    output logic                o_valid,
    output nv12dt_pkg::t_result o_data,
    input  logic                i_stall
);
    import nv12dt_pkg::*;

    logic    r_head_valid, n_head_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_head, n_head;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop = r_head_valid && !i_stall;

    always_comb begin
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head       = r_head;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_head_valid = 1'b1;
                n_head       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_head_valid = i_push;
                n_head       = i_data;
            end
        end else if (!r_head_valid) begin
            n_head_valid = i_push;
            n_head       = i_data;
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_data  = r_head;

    `ASSERT_CLK(a_skid_needs_head, i_clk, i_rst_n, r_skid_valid |-> r_head_valid)
    `ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, i_push && r_skid_valid)
    `ASSERT_CLK(a_skid_held_on_stall, i_clk, i_rst_n, r_skid_valid && i_stall |=> r_skid_valid)

endmodule

`default_nettype wire

// ===== rtl/core/tiled_nv12_detiler_core.sv =====
// Top level of the tiled NV12 to planar YUV 4:2:0 detiler.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// The detiler takes the 32-bit words of a tiled NV12 frame in memory order:
// the luma plane as 16x16-byte tiles, then the interleaved Cb/Cr plane as
// 16x8-byte tiles, tiles row-major with the width padded to 16. Each word
// that touches the image becomes one planar write carrying a byte address,
// four lane bytes and a lane mask; a word wholly outside the image is
// consumed with no write. Chroma writes put the Cb pair on lanes 0-1 and the
// Cr pair on lanes 2-3 at the same address. The block takes one word per
// clock cycle while o_stall is low; each write is registered in the output
// buffer. The walk counters, the row-by-width multiplier and the address
// adder sit between the counter registers and the output register, and that
// path sets the clock rate. A two-entry output buffer lets a word be taken
// while a finished write waits; i_valid is stalled only when both entries
// are full. The user must write the width and height registers through the
// plain write port only while the block is idle, which it does not enforce.
// A zero acts as one, a value above MAX_WIDTH or MAX_HEIGHT as that maximum.

module tiled_nv12_detiler_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  nv12dt_pkg::t_cfg_idx              i_cfg_index,
    input  logic [nv12dt_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [31:0]                       i_tiled_word,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_is_chroma,
    output logic [nv12dt_pkg::ADDR_W-1:0]     o_linear_address,
    output logic [7:0]                        o_lane0_byte,
    output logic [7:0]                        o_lane1_byte,
    output logic [7:0]                        o_lane2_byte,
    output logic [7:0]                        o_lane3_byte,
    output logic [3:0]                        o_lane_mask,
    output logic                              o_frame_last
);
    import nv12dt_pkg::*;

    // Counter widths follow from the largest frame the block is built for.
    localparam int MAX_COLS  = (MAX_WIDTH + TILE_W - 1) / TILE_W;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int MAX_TROWS = (MAX_HEIGHT + LUMA_TILE_H - 1) / LUMA_TILE_H;
    localparam int ROW_W     = (MAX_TROWS > 1) ? $clog2(MAX_TROWS) : 1;
    localparam int PROD_W    = POS_W + CFG_W;

    // Configuration registers.
    logic [CFG_W-1:0] r_width, n_width;
    logic [CFG_W-1:0] r_height, n_height;

    // Walk through the tiled buffer.
    logic [COL_W-1:0] r_tile_col, n_tile_col;
    logic [ROW_W-1:0] r_tile_row, n_tile_row;
    logic [3:0]       r_row_in_tile, n_row_in_tile;
    logic [1:0]       r_word, n_word;
    logic             r_chroma, n_chroma;

    logic             accept;
    logic             buf_full;

    // Effective frame geometry.
    logic [CFG_W-1:0] w_c, h_c;
    logic [CFG_W-2:0] cw, ch;
    logic [COL_W:0]   ncols;
    logic [ROW_W:0]   luma_trows, chroma_trows, nrows;
    logic [4:0]       tile_h;

    // Position of the current word.
    logic [POS_W-1:0] row_l, x_l, row_c, cx, row, col;
    logic [PROD_W-1:0] prod, offs, sum;
    logic [3:0]       mask;
    logic             last;
    t_result          result;

    // Carry chain of the walk.
    logic [4:0]       rit_inc;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;

    // Clamp the register values to the supported range.
    always_comb begin
        if (r_width == '0) begin
            w_c = CFG_W'(1);
        end else if ({1'b0, r_width} > (CFG_W + 1)'(MAX_WIDTH)) begin
            w_c = CFG_W'(MAX_WIDTH);
        end else begin
            w_c = r_width;
        end
        if (r_height == '0) begin
            h_c = CFG_W'(1);
        end else if ({1'b0, r_height} > (CFG_W + 1)'(MAX_HEIGHT)) begin
            h_c = CFG_W'(MAX_HEIGHT);
        end else begin
            h_c = r_height;
        end
    end

    assign cw = w_c[CFG_W-1:1];
    assign ch = h_c[CFG_W-1:1];
    assign ncols = (COL_W + 1)'((POS_W'(w_c) + POS_W'(TILE_W - 1)) >> TILE_W_LOG2);
    assign luma_trows =
        (ROW_W + 1)'((POS_W'(h_c) + POS_W'(LUMA_TILE_H - 1)) >> TILE_W_LOG2);
    assign chroma_trows =
        (ROW_W + 1)'((POS_W'(ch) + POS_W'(CHROMA_TILE_H - 1)) >> CHROMA_TILE_H_LOG2);
    assign nrows  = r_chroma ? chroma_trows : luma_trows;
    assign tile_h = r_chroma ? 5'(CHROMA_TILE_H) : 5'(LUMA_TILE_H);

    // Luma words cover four pixels of one row; chroma words cover two
    // interleaved Cb/Cr pairs.
    assign row_l = (POS_W'(r_tile_row) << 4) + POS_W'(r_row_in_tile);
    assign x_l   = (POS_W'(r_tile_col) << 4) + (POS_W'(r_word) << 2);
    assign row_c = (POS_W'(r_tile_row) << 3) + POS_W'(r_row_in_tile);
    assign cx    = (POS_W'(r_tile_col) << 3) + (POS_W'(r_word) << 1);
    assign row   = r_chroma ? row_c : row_l;
    assign col   = r_chroma ? cx : x_l;

    always_comb begin
        mask = '0;
        if (r_chroma) begin
            if (row_c < POS_W'(ch)) begin
                mask[0] = cx < POS_W'(cw);
                mask[2] = cx < POS_W'(cw);
                mask[1] = (cx + POS_W'(1)) < POS_W'(cw);
                mask[3] = (cx + POS_W'(1)) < POS_W'(cw);
            end
        end else begin
            for (int j = 0; j < 4; j++) begin
                mask[j] = (row_l < POS_W'(h_c)) && ((x_l + POS_W'(j)) < POS_W'(w_c));
            end
        end
    end

    // Luma address is row*W + x. Chroma keeps the (row*W)/2 + cx form, so an
    // odd width rounds the row offset down.
    assign prod = PROD_W'(row) * PROD_W'(w_c);
    assign offs = r_chroma ? (prod >> 1) : prod;
    assign sum  = offs + PROD_W'(col);

    // The frame ends on the chroma word holding the last pixel pair of the
    // last chroma row.
    assign last = r_chroma
        && (row_c == (POS_W'(ch) - POS_W'(1)))
        && (((POS_W'(r_tile_col) << 2) + POS_W'(r_word))
            == ((POS_W'(cw) - POS_W'(1)) >> 1));

    always_comb begin
        result.is_chroma      = r_chroma;
        result.linear_address = ADDR_W'(sum);
        result.lanes[0]       = i_tiled_word[7:0];
        result.lanes[1]       = r_chroma ? i_tiled_word[23:16] : i_tiled_word[15:8];
        result.lanes[2]       = r_chroma ? i_tiled_word[15:8] : i_tiled_word[23:16];
        result.lanes[3]       = i_tiled_word[31:24];
        result.lane_mask      = mask;
        result.frame_last     = last;
    end

    assign o_stall = buf_full;
    assign accept  = i_valid && !buf_full;

    // Advance the walk on every transferred word, whether or not it writes.
    // A counter at or past a newly written bound carries at its next step.
    assign rit_inc = {1'b0, r_row_in_tile} + 5'd1;
    assign col_inc = {1'b0, r_tile_col} + (COL_W + 1)'(1);
    assign row_inc = {1'b0, r_tile_row} + (ROW_W + 1)'(1);

    always_comb begin
        n_word        = r_word;
        n_row_in_tile = r_row_in_tile;
        n_tile_col    = r_tile_col;
        n_tile_row    = r_tile_row;
        n_chroma      = r_chroma;
        if (accept) begin
            n_word = r_word + 2'd1;
            if (r_word == 2'(WORDS_PER_ROW - 1)) begin
                if (rit_inc < tile_h) begin
                    n_row_in_tile = rit_inc[3:0];
                end else begin
                    n_row_in_tile = '0;
                    if (col_inc < ncols) begin
                        n_tile_col = col_inc[COL_W-1:0];
                    end else begin
                        n_tile_col = '0;
                        if (row_inc < nrows) begin
                            n_tile_row = row_inc[ROW_W-1:0];
                        end else begin
                            n_tile_row = '0;
                            // A one-row frame has no chroma plane at all.
                            n_chroma = !r_chroma && (ch != '0);
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  n_width  = i_cfg_data;
                CFG_IMAGE_HEIGHT: n_height = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= WIDTH_RESET;
            r_height      <= HEIGHT_RESET;
            r_tile_col    <= '0;
            r_tile_row    <= '0;
            r_row_in_tile <= '0;
            r_word        <= '0;
            r_chroma      <= 1'b0;
        end else begin
            r_width       <= n_width;
            r_height      <= n_height;
            r_tile_col    <= n_tile_col;
            r_tile_row    <= n_tile_row;
            r_row_in_tile <= n_row_in_tile;
            r_word        <= n_word;
            r_chroma      <= n_chroma;
        end
    end

    t_result out_data;

    nv12dt_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && (mask != '0)),
        .i_data  (result),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (out_data),
        .i_stall (i_stall)
    );

    assign o_is_chroma      = out_data.is_chroma;
    assign o_linear_address = out_data.linear_address;
    assign o_lane0_byte     = out_data.lanes[0];
    assign o_lane1_byte     = out_data.lanes[1];
    assign o_lane2_byte     = out_data.lanes[2];
    assign o_lane3_byte     = out_data.lanes[3];
    assign o_lane_mask      = out_data.lane_mask;
    assign o_frame_last     = out_data.frame_last;

    `ASSERT_CLK(a_write_has_lane, i_clk, i_rst_n, o_valid |-> (o_lane_mask != 4'b0000))
    `ASSERT_CLK(a_last_is_chroma, i_clk, i_rst_n, o_valid && o_frame_last |-> o_is_chroma)
    `ASSERT_CLK(a_chroma_mask_pairs, i_clk, i_rst_n, o_valid && o_is_chroma |-> (o_lane_mask[0] == o_lane_mask[2]) && (o_lane_mask[1] == o_lane_mask[3]))

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the tiled NV12 detiler core.
`timescale 1ns / 1ps

module testbench;
    import nv12dt_pkg::*;

    localparam int MAX_W         = 4096;
    localparam int MAX_H         = 4096;
    localparam int WORD_TARGET   = 1600;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int MAX_PRINTS    = 40;

    // One planar write as the block presents it on its output ports.
    typedef struct packed {
        logic              is_chroma;
        logic [ADDR_W-1:0] linear_address;
        logic [7:0]        lane0;
        logic [7:0]        lane1;
        logic [7:0]        lane2;
        logic [7:0]        lane3;
        logic [3:0]        lane_mask;
        logic              frame_last;
    } t_planar_write;

    // A row of the directed table is either a register write, a word checked
    // against the predictor, or a luma word whose write is typed in here.
    typedef enum logic [1:0] {ROW_CFG, ROW_WORD, ROW_KNOWN} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_cfg_idx          index;
        logic [CFG_W-1:0]  value;
        logic [31:0]       word;
        logic [ADDR_W-1:0] want_address;
        logic [3:0]        want_mask;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [31:0]           i_tiled_word;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_is_chroma;
    logic [ADDR_W-1:0]     o_linear_address;
    logic [7:0]            o_lane0_byte;
    logic [7:0]            o_lane1_byte;
    logic [7:0]            o_lane2_byte;
    logic [7:0]            o_lane3_byte;
    logic [3:0]            o_lane_mask;
    logic                  o_frame_last;

    tiled_nv12_detiler_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_tiled_word     (i_tiled_word),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_is_chroma      (o_is_chroma),
        .o_linear_address (o_linear_address),
        .o_lane0_byte     (o_lane0_byte),
        .o_lane1_byte     (o_lane1_byte),
        .o_lane2_byte     (o_lane2_byte),
        .o_lane3_byte     (o_lane3_byte),
        .o_lane_mask      (o_lane_mask),
        .o_frame_last     (o_frame_last)
    );

    // Writes predicted for words already transferred, oldest first.
    t_planar_write planar_writes_due[$];

    // Shadow of the width and height registers and of the tile walk.
    logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
    int unsigned walk_col       = 0;
    int unsigned walk_tile_row  = 0;
    int unsigned walk_line      = 0;
    int unsigned walk_word      = 0;
    int unsigned in_chroma      = 0;

    int unsigned words_in    = 0;
    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_hold  = 0;
    bit          calm        = 1'b0;

    // Directed part: the reset geometry first, then register extremes (zero,
    // just past the maximum, all ones, the maximum itself), an odd width, a
    // height with a single chroma row, and a width of one, all written while
    // the walk is in the middle of a luma tile so that the counters must carry
    // against bounds that moved under them.
    t_stim_row directed [23] = '{
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0,    32'h44332211, 24'd0,    4'hf},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0,    32'hffffffff, 24'd4,    4'hf},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0,    32'h00000000, 24'd8,    4'hf},
        '{ROW_CFG,   CFG_IMAGE_WIDTH,  13'd0,    32'h0,        24'd0,    4'h0},
        '{ROW_CFG,   CFG_IMAGE_HEIGHT, 13'd0,    32'h0,        24'd0,    4'h0},
        '{ROW_WORD,  CFG_IMAGE_WIDTH,  13'd0,    32'h80000001, 24'd0,    4'h0},
        '{ROW_WORD,  CFG_IMAGE_WIDTH,  13'd0,    32'h7fffffff, 24'd0,    4'h0},
        '{ROW_CFG,   CFG_IMAGE_WIDTH,  13'd8191, 32'h0,        24'd0,    4'h0},
        '{ROW_CFG,   CFG_IMAGE_HEIGHT, 13'd8191, 32'h0,        24'd0,    4'h0},
        '{ROW_KNOWN, CFG_IMAGE_WIDTH,  13'd0,    32'ha5a5a5a5, 24'd4100, 4'hf},
        '{ROW_CFG,   CFG_IMAGE_WIDTH,  13'd4097, 32'h0,        24'd0,    4'h0},
        '{ROW_CFG,   CFG_IMAGE_HEIGHT, 13'd4097, 32'h0,        24'd0,    4'h0},
        '{ROW_WORD,  CFG_IMAGE_WIDTH,  13'd0,    32'h5a5a5a5a, 24'd0,    4'h0},
        '{ROW_CFG,   CFG_IMAGE_WIDTH,  13'd7,    32'h0,        24'd0,    4'h0},
        '{ROW_CFG,   CFG_IMAGE_HEIGHT, 13'd3,    32'h0,        24'd0,    4'h0},
        '{ROW_WORD,  CFG_IMAGE_WIDTH,  13'd0,    32'h0f0f0f0f, 24'd0,    4'h0},
        '{ROW_WORD,  CFG_IMAGE_WIDTH,  13'd0,    32'hf0f0f0f0, 24'd0,    4'h0},
        '{ROW_WORD,  CFG_IMAGE_WIDTH,  13'd0,    32'h12345678, 24'd0,    4'h0},
        '{ROW_CFG,   CFG_IMAGE_WIDTH,  13'd4096, 32'h0,        24'd0,    4'h0},
        '{ROW_CFG,   CFG_IMAGE_HEIGHT, 13'd1,    32'h0,        24'd0,    4'h0},
        '{ROW_WORD,  CFG_IMAGE_WIDTH,  13'd0,    32'h89abcdef, 24'd0,    4'h0},
        '{ROW_CFG,   CFG_IMAGE_WIDTH,  13'd1,    32'h0,        24'd0,    4'h0},
        '{ROW_WORD,  CFG_IMAGE_WIDTH,  13'd0,    32'h00ff00ff, 24'd0,    4'h0}
    };

    always #5 i_clk = ~i_clk;

    // Steps the tile walk by one word. A counter that sits at or past a bound
    // that shrank since it was set carries on this step like one at the bound.
    function automatic void step_walk(input int unsigned n_cols,
                                      input int unsigned n_tile_rows,
                                      input int unsigned tile_h);
        walk_word++;
        if (walk_word < WORDS_PER_ROW) return;
        walk_word = 0;
        walk_line++;
        if (walk_line < tile_h) return;
        walk_line = 0;
        walk_col++;
        if (walk_col < n_cols) return;
        walk_col = 0;
        walk_tile_row++;
        if (walk_tile_row < n_tile_rows) return;
        walk_tile_row = 0;
        in_chroma ^= 1;
    endfunction

    // Maps one tiled word to its planar write and advances the walk. Returns
    // one when at least one byte of the word lies inside the image.
    function automatic bit detile_word(input logic [31:0] word, output t_planar_write wr);
        int unsigned w, h, cw, ch, n_cols, line, px;
        w  = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
        h  = (height_reg == 0) ? 1 : (height_reg > MAX_H) ? MAX_H : height_reg;
        cw = w / 2;
        ch = h / 2;
        n_cols = (w + TILE_W - 1) / TILE_W;
        wr = '0;
        if (in_chroma == 0) begin
            line = walk_tile_row * LUMA_TILE_H + walk_line;
            px   = walk_col * TILE_W + walk_word * 4;
            if (line < h) begin
                for (int j = 0; j < 4; j++) begin
                    if (px + j < w) wr.lane_mask[j] = 1'b1;
                end
            end
            wr.linear_address = ADDR_W'(line * w + px);
            wr.lane0 = word[7:0];
            wr.lane1 = word[15:8];
            wr.lane2 = word[23:16];
            wr.lane3 = word[31:24];
            step_walk(n_cols, (h + LUMA_TILE_H - 1) / LUMA_TILE_H, LUMA_TILE_H);
            // A height of one leaves no chroma rows, so the next frame's luma
            // follows straight away.
            if (in_chroma != 0 && ch == 0) in_chroma = 0;
        end else begin
            line = walk_tile_row * CHROMA_TILE_H + walk_line;
            px   = walk_col * (TILE_W / 2) + walk_word * 2;
            if (line < ch) begin
                if (px < cw) wr.lane_mask |= 4'b0101;
                if (px + 1 < cw) wr.lane_mask |= 4'b1010;
            end
            wr.is_chroma = 1'b1;
            // The chroma address keeps the halved luma row offset, which
            // differs from row * (W/2) when the width is odd.
            wr.linear_address = ADDR_W'((line * w) / 2 + px);
            // Cb bytes sit at even offsets and Cr bytes at odd offsets.
            wr.lane0 = word[7:0];
            wr.lane1 = word[23:16];
            wr.lane2 = word[15:8];
            wr.lane3 = word[31:24];
            if (wr.lane_mask != 0 && line == ch - 1
                    && walk_col * WORDS_PER_ROW + walk_word == (cw - 1) / 2)
                wr.frame_last = 1'b1;
            step_walk(n_cols, (ch + CHROMA_TILE_H - 1) / CHROMA_TILE_H, CHROMA_TILE_H);
        end
        return wr.lane_mask != 0;
    endfunction

    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    // Called at a falling edge. Offers one word, waits for its transfer and
    // then records the write it must produce. A known write from the table
    // replaces the predicted one, though the walk still advances.
    task automatic send_word(input logic [31:0] word, input bit known,
                             input logic [ADDR_W-1:0] want_address, input logic [3:0] want_mask);
        int unsigned pause;
        t_planar_write wr;
        bit produces;
        pause = pick_pause();
        if (pause != 0) begin
            i_valid <= 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_tiled_word <= word;
        do @(posedge i_clk); while (o_stall);
        words_in++;
        produces = detile_word(word, wr);
        if (known) begin
            produces = 1'b1;
            wr = '{1'b0, want_address, word[7:0], word[15:8], word[23:16], word[31:24],
                   want_mask, 1'b0};
        end
        if (produces) planar_writes_due.push_back(wr);
        @(negedge i_clk);
    endtask

    // Called at a falling edge. Registers only change with the block idle:
    // every write is out and the output buffer has had time to empty even
    // when the last words produced nothing.
    task automatic write_reg(input t_cfg_idx index, input logic [CFG_W-1:0] value);
        i_valid <= 1'b0;
        while (planar_writes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        if (index == CFG_IMAGE_WIDTH) width_reg = value;
        else height_reg = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Output side: compare every transferred write with the oldest prediction.
    always @(posedge i_clk) begin
        t_planar_write want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (planar_writes_due.size() == 0) begin
                report_mismatch("write with nothing pending", 32'(o_linear_address), 32'd0);
            end else begin
                want = planar_writes_due.pop_front();
                if (o_is_chroma !== want.is_chroma)
                    report_mismatch("is_chroma", 32'(o_is_chroma), 32'(want.is_chroma));
                if (o_linear_address !== want.linear_address)
                    report_mismatch("linear_address", 32'(o_linear_address),
                                    32'(want.linear_address));
                if (o_lane0_byte !== want.lane0)
                    report_mismatch("lane0_byte", 32'(o_lane0_byte), 32'(want.lane0));
                if (o_lane1_byte !== want.lane1)
                    report_mismatch("lane1_byte", 32'(o_lane1_byte), 32'(want.lane1));
                if (o_lane2_byte !== want.lane2)
                    report_mismatch("lane2_byte", 32'(o_lane2_byte), 32'(want.lane2));
                if (o_lane3_byte !== want.lane3)
                    report_mismatch("lane3_byte", 32'(o_lane3_byte), 32'(want.lane3));
                if (o_lane_mask !== want.lane_mask)
                    report_mismatch("lane_mask", 32'(o_lane_mask), 32'(want.lane_mask));
                if (o_frame_last !== want.frame_last)
                    report_mismatch("frame_last", 32'(o_frame_last), 32'(want.frame_last));
            end
        end
    end

    // Receiver back-pressure: mostly short runs, now and then a long stall,
    // and no new stall starts while a calm phase is running.
    always @(negedge i_clk) begin
        int unsigned roll;
        if (stall_hold != 0) begin
            stall_hold--;
        end else begin
            roll = $urandom_range(0, 99);
            if (calm || roll < 60) begin
                i_stall    <= 1'b0;
                stall_hold = $urandom_range(0, 6);
            end else if (roll < 92) begin
                i_stall    <= 1'b1;
                stall_hold = $urandom_range(0, 2);
            end else begin
                i_stall    <= 1'b1;
                stall_hold = $urandom_range(8, 40);
            end
        end
    end

    // Watchdog: too many cycles in a row without a transfer on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tiled_nv12_detiler_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned w_pick, h_pick, kind, frames;
        bit partial;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_IMAGE_WIDTH;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_tiled_word = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            case (directed[k].kind)
                ROW_CFG: begin
                    write_reg(directed[k].index, directed[k].value);
                end
                ROW_KNOWN: begin
                    send_word(directed[k].word, 1'b1, directed[k].want_address,
                              directed[k].want_mask);
                end
                default: begin
                    send_word(directed[k].word, 1'b0, '0, '0);
                end
            endcase
        end

        // Random part. Most phases pick a small geometry and stream whole
        // frames of random words, so that the walk crosses tile, plane and
        // frame boundaries and reaches the last chroma write. The others use
        // extreme register values, or stop partway, so that the next phase
        // moves the bounds while the walk is mid-frame.
        while (words_in < WORD_TARGET) begin
            calm    = ($urandom_range(0, 4) == 0);
            partial = 1'b0;
            kind    = $urandom_range(0, 15);
            case (kind)
                0: begin
                    case ($urandom_range(0, 5))
                        0: w_pick = 0;
                        1: w_pick = 1;
                        2: w_pick = MAX_W;
                        3: w_pick = MAX_W + 1;
                        4: w_pick = 8191;
                        default: w_pick = $urandom_range(0, 8191);
                    endcase
                    h_pick  = $urandom_range(1, 40);
                    partial = 1'b1;
                end
                1: begin
                    case ($urandom_range(0, 3))
                        0: h_pick = 0;
                        1: h_pick = MAX_H;
                        2: h_pick = MAX_H + 1;
                        default: h_pick = 8191;
                    endcase
                    w_pick  = $urandom_range(1, 40);
                    partial = 1'b1;
                end
                2: begin
                    // A one-pixel-wide frame has no chroma byte in the image.
                    w_pick = 1;
                    h_pick = $urandom_range(1, 20);
                end
                3: begin
                    // One or two rows: no chroma plane, or a single chroma row.
                    w_pick = $urandom_range(1, 40);
                    h_pick = $urandom_range(1, 2);
                end
                4: begin
                    w_pick = $urandom_range(1, 15) * 2 + 1;
                    h_pick = $urandom_range(2, 34);
                end
                default: begin
                    w_pick  = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 48 : 16);
                    h_pick  = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 34 : 18);
                    partial = ($urandom_range(0, 5) == 0);
                end
            endcase
            write_reg(CFG_IMAGE_WIDTH, CFG_W'(w_pick));
            write_reg(CFG_IMAGE_HEIGHT, CFG_W'(h_pick));
            if (partial) begin
                repeat ($urandom_range(8, 200)) send_word($urandom, 1'b0, '0, '0);
            end else begin
                // Run to the next frame boundary, then possibly one frame more.
                frames = $urandom_range(1, 2);
                repeat (frames) begin
                    do send_word($urandom, 1'b0, '0, '0);
                    while ((walk_col | walk_tile_row | walk_line | walk_word | in_chroma) != 0);
                end
            end
        end

        i_valid <= 1'b0;
        while (planar_writes_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tiled_nv12_detiler_core verification clean");
        end else begin
            $display("tiled_nv12_detiler_core verification failed");
        end
        $finish;
    end

endmodule
